// File: sv/mcv_pkg.sv
// Package for the motion completion verifier: widths, codes, token struct.
// Used by every module of the block; depends on nothing.
package mcv_pkg;

    localparam int COORD_W     = 24;
    localparam int TOL_W       = 20;
    localparam int TMO_W       = 16;
    localparam int WAIT_W      = 17;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int SUM_W       = SQ_W + 2;
    localparam int TOLSQ_W     = 2 * TOL_W;
    localparam int MAX_LANES   = 6;
    localparam int CART_LANES  = 3;
    localparam int NUM_JOINTS_DEF = 6;

    localparam logic [TMO_W-1:0]  TIMEOUT_RST = TMO_W'(2000);
    localparam logic [WAIT_W-1:0] WAIT_MAX    = {WAIT_W{1'b1}};

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_REPORT = 3'd1;
    localparam logic [2:0] FUNC_LIN    = 3'd2;
    localparam logic [2:0] FUNC_JCART  = 3'd3;
    localparam logic [2:0] FUNC_JOINT  = 3'd4;
    localparam logic [2:0] FUNC_UNSUP  = 3'd5;

    localparam logic [1:0] FB_BUSY     = 2'd0;
    localparam logic [1:0] FB_ACCEPTED = 2'd1;
    localparam logic [1:0] FB_REACHED  = 2'd2;
    localparam logic [1:0] FB_FAILED   = 2'd3;

    typedef enum logic [1:0] {
        KIND_LIN   = 2'd0,
        KIND_JCART = 2'd1,
        KIND_JOINT = 2'd2,
        KIND_UNSUP = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_MOVING = 2'd2
    } t_phase;

    typedef struct packed {
        logic       verify;
        logic [1:0] fb;
        t_kind      kind;
    } t_tok;

endpackage

// File: sv/mcv_lane.sv
// One compare lane: absolute error, then its square and the per-axis limit check.
// Depends on mcv_pkg.
module mcv_lane (
    input  logic                              i_clk,
    input  logic                              i_en_a,
    input  logic                              i_en_b,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_actual,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_target,
    input  logic        [mcv_pkg::TOL_W-1:0]   i_tol,
    output logic        [mcv_pkg::SQ_W-1:0]    o_sq,
    output logic                              o_ok
);
    import mcv_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] n_mag;
    logic        [DIFF_W-1:0] r_mag;
    logic        [2*DIFF_W-1:0] prod;
    logic        [SQ_W-1:0]   r_sq;
    logic                     r_ok;

    assign diff  = DIFF_W'(i_actual) - DIFF_W'(i_target);
    assign n_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prod  = r_mag * r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_mag <= n_mag;
        end
        if (i_en_b) begin
            r_sq <= prod[SQ_W-1:0];
            r_ok <= (r_mag <= DIFF_W'(i_tol));
        end
    end

    assign o_sq = r_sq;
    assign o_ok = r_ok;
endmodule

// File: sv/mcv_merge.sv
// Merging stage: combines the lane results into the verification answer.
// Depends on mcv_pkg.
module mcv_merge (
    input  mcv_pkg::t_tok                     i_tok,
    input  logic [mcv_pkg::SQ_W-1:0]          i_sq_0,
    input  logic [mcv_pkg::SQ_W-1:0]          i_sq_1,
    input  logic [mcv_pkg::SQ_W-1:0]          i_sq_2,
    input  logic [mcv_pkg::MAX_LANES-1:0]     i_ok,
    input  logic [mcv_pkg::TOLSQ_W-1:0]       i_tolsq,
    output logic [1:0]                        o_fb
);
    import mcv_pkg::*;

    logic [SUM_W-1:0] sum;
    logic             pass;

    assign sum = SUM_W'(i_sq_0) + SUM_W'(i_sq_1) + SUM_W'(i_sq_2);

    always_comb begin
        unique case (i_tok.kind)
            KIND_LIN, KIND_JCART: pass = (sum <= SUM_W'(i_tolsq));
            KIND_JOINT:           pass = &i_ok;
            default:              pass = 1'b0;
        endcase
        if (i_tok.verify) begin
            o_fb = pass ? FB_REACHED : FB_FAILED;
        end else begin
            o_fb = i_tok.fb;
        end
    end
endmodule

// File: sv/motion_completion_verifier_top.sv
// Top level of the motion completion verifier: phase control, lanes, merge, output.
// Depends on mcv_pkg, mcv_lane and mcv_merge.
//
// The input channel carries commands, state reports and time ticks; each
// transaction is taken at a rising edge with i_in_valid high and o_in_stall low.
// Commands and verifying state reports produce one feedback transaction on
// the output channel; ticks and ignored reports produce none.
// The phase, tick count and stored target update at the accepting edge, so
// a new transaction may follow in the very next cycle.
// The result passes a difference stage, a square stage and the output
// register, which drives o_out_valid.
// Throughput is one transaction per cycle while o_in_stall is low, set by the pipelined lanes.
// While the receiver holds i_out_stall, the pipeline keeps filling its empty
// stages and raises o_in_stall only when every stage holds a result.
// The timeout register is written through i_cfg_wr_en and i_cfg_wr_data.
// A synchronous reset empties the pipeline, returns to idle and loads a
// timeout of 2000 ticks; the stored target stays undefined until a command.
module motion_completion_verifier_top #(
    parameter int NUM_JOINTS = mcv_pkg::NUM_JOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic        [mcv_pkg::TMO_W-1:0]   i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic        [2:0]                  i_func,
    input  logic                               i_motion_done,
    input  logic        [mcv_pkg::TOL_W-1:0]   i_tolerance,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_0,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_1,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_2,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_3,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_4,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_coord_5,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_cart_x,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_cart_y,
    input  logic signed [mcv_pkg::COORD_W-1:0] i_cart_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic        [1:0]                  o_feedback
);
    import mcv_pkg::*;

    logic [TMO_W-1:0]  r_timeout;
    t_phase            r_phase, n_phase;
    logic [WAIT_W-1:0] r_wait, n_wait;
    t_kind             r_kind, n_kind;
    logic [TOL_W-1:0]  r_goal_tol, n_goal_tol;
    logic signed [COORD_W-1:0] r_target [MAX_LANES];
    logic signed [COORD_W-1:0] coord_in [MAX_LANES];
    logic signed [COORD_W-1:0] cart_in  [CART_LANES];
    logic signed [COORD_W-1:0] actual   [MAX_LANES];
    logic              load_target;

    logic              acc;
    logic              has_res;
    t_tok              n_tok;
    logic              cart_kind;

    logic              r_v1, r_v2, r_ov;
    t_tok              r_tok1, r_tok2;
    logic [TOL_W-1:0]  r_tol1;
    logic [TOLSQ_W-1:0] r_tolsq2;
    logic [1:0]        r_fb;
    logic              out_rdy, s2_free, s1_free;

    logic [SQ_W-1:0]      lane_sq [MAX_LANES];
    logic [MAX_LANES-1:0] lane_ok;
    logic [1:0]           merge_fb;

    assign coord_in[0] = i_coord_0;
    assign coord_in[1] = i_coord_1;
    assign coord_in[2] = i_coord_2;
    assign coord_in[3] = i_coord_3;
    assign coord_in[4] = i_coord_4;
    assign coord_in[5] = i_coord_5;
    assign cart_in[0]  = i_cart_x;
    assign cart_in[1]  = i_cart_y;
    assign cart_in[2]  = i_cart_z;

    assign out_rdy    = !r_ov || !i_out_stall;
    assign s2_free    = !r_v2 || out_rdy;
    assign s1_free    = !r_v1 || s2_free;
    assign o_in_stall = !s1_free;
    assign acc        = i_in_valid && s1_free;
    assign cart_kind  = (r_kind == KIND_LIN) || (r_kind == KIND_JCART);

    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_kind      = r_kind;
        n_goal_tol  = r_goal_tol;
        load_target = 1'b0;
        has_res     = 1'b0;
        n_tok       = '{verify: 1'b0, fb: FB_BUSY, kind: r_kind};
        if (acc) begin
            unique case (i_func)
                FUNC_TICK: begin
                    if (r_phase == PH_WAIT && r_wait != WAIT_MAX) begin
                        n_wait = r_wait + WAIT_W'(1);
                    end
                end
                FUNC_REPORT: begin
                    priority if (r_phase == PH_WAIT) begin
                        if (!i_motion_done) begin
                            n_phase = PH_MOVING;
                        end else if (r_wait > WAIT_W'(r_timeout)) begin
                            has_res      = 1'b1;
                            n_tok.verify = 1'b1;
                            n_phase      = PH_IDLE;
                        end
                    end else if (r_phase == PH_MOVING) begin
                        if (i_motion_done) begin
                            has_res      = 1'b1;
                            n_tok.verify = 1'b1;
                            n_phase      = PH_IDLE;
                        end
                    end else begin
                    end
                end
                FUNC_LIN, FUNC_JCART, FUNC_JOINT, FUNC_UNSUP: begin
                    has_res = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        n_kind      = t_kind'(2'(i_func - FUNC_LIN));
                        n_goal_tol  = i_tolerance;
                        load_target = 1'b1;
                        n_phase     = PH_WAIT;
                        n_wait      = '0;
                        n_tok.fb    = FB_ACCEPTED;
                    end else begin
                        n_tok.fb    = FB_BUSY;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_phase    <= PH_IDLE;
            r_wait     <= '0;
            r_kind     <= KIND_LIN;
            r_goal_tol <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_kind     <= n_kind;
            r_goal_tol <= n_goal_tol;
            if (s1_free) begin
                r_v1 <= acc && has_res;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_rdy) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_target) begin
            for (int k = 0; k < MAX_LANES; k++) begin
                r_target[k] <= coord_in[k];
            end
        end
        if (s1_free) begin
            r_tok1 <= n_tok;
            r_tol1 <= r_goal_tol;
        end
        if (s2_free) begin
            r_tok2   <= r_tok1;
            r_tolsq2 <= r_tol1 * r_tol1;
        end
        if (out_rdy) begin
            r_fb <= merge_fb;
        end
    end

    for (genvar gi = 0; gi < MAX_LANES; gi++) begin : g_lane
        if (gi < CART_LANES) begin : g_mux
            assign actual[gi] = cart_kind ? cart_in[gi] : coord_in[gi];
        end else begin : g_joint
            assign actual[gi] = coord_in[gi];
        end
        if (gi < CART_LANES || gi < NUM_JOINTS) begin : g_used
            logic ok_raw;
            mcv_lane u_lane (
                .i_clk    (i_clk),
                .i_en_a   (s1_free),
                .i_en_b   (s2_free),
                .i_actual (actual[gi]),
                .i_target (r_target[gi]),
                .i_tol    (r_tol1),
                .o_sq     (lane_sq[gi]),
                .o_ok     (ok_raw)
            );
            assign lane_ok[gi] = (gi < NUM_JOINTS) ? ok_raw : 1'b1;
        end else begin : g_unused
            assign lane_sq[gi] = '0;
            assign lane_ok[gi] = 1'b1;
        end
    end

    mcv_merge u_merge (
        .i_tok   (r_tok2),
        .i_sq_0  (lane_sq[0]),
        .i_sq_1  (lane_sq[1]),
        .i_sq_2  (lane_sq[2]),
        .i_ok    (lane_ok),
        .i_tolsq (r_tolsq2),
        .o_fb    (merge_fb)
    );

    assign o_out_valid = r_ov;
    assign o_feedback  = r_fb;
endmodule

// File: test/tb_motion_completion_verifier_top.sv
`timescale 1ns / 100ps
// Testbench for motion_completion_verifier_top: directed table, then random motions under idling.
// Depends on mcv_pkg and the verifier RTL; a built-in predictor or the table checks each feedback.
module tb_motion_completion_verifier_top;
    import mcv_pkg::*;

    localparam int JOINTS = NUM_JOINTS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 270;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
    localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_FB
    } t_check;

    typedef struct packed {
        logic [2:0]                         func;
        logic                               done;
        logic [TOL_W-1:0]                   tol;
        logic [MAX_LANES-1:0][COORD_W-1:0]  coord;
        logic [CART_LANES-1:0][COORD_W-1:0] cart;
    } t_item;

    typedef struct packed {
        logic [2:0]         func;
        logic               done;
        logic [TOL_W-1:0]   tol;
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] cart;
        t_check             check;
        logic [1:0]         fb;
    } t_row;

    localparam int N_ROWS = 25;
    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{FUNC_REPORT, 1'b1, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_TICK, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_RSVD6, 1'b1, TOL_MAX, COORD_MAX, COORD_MIN, CHK_NONE, FB_BUSY},
        '{FUNC_RSVD7, 1'b0, '0, COORD_MIN, COORD_MAX, CHK_NONE, FB_BUSY},
        '{FUNC_LIN, 1'b0, '0, '0, '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_LIN, 1'b1, TOL_MAX, COORD_MAX, COORD_MAX, CHK_FB, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, '0, CHK_FB, FB_REACHED},
        '{FUNC_JOINT, 1'b0, TOL_MAX, COORD_MAX, '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_JOINT, 1'b0, '0, COORD_MIN, '0, CHK_FB, FB_BUSY},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, COORD_MIN, '0, CHK_FB, FB_FAILED},
        '{FUNC_UNSUP, 1'b1, TOL_MAX, '0, '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, '0, CHK_FB, FB_FAILED},
        '{FUNC_JCART, 1'b0, TOL_MAX, COORD_MIN, '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, COORD_MAX, CHK_FB, FB_FAILED},
        '{FUNC_LIN, 1'b0, 20'd1000, COORD_MAX, '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, COORD_MAX - 24'd577, CHK_PRED, FB_BUSY},
        '{FUNC_JOINT, 1'b0, 20'd5, COORD_W'(-5), '0, CHK_FB, FB_ACCEPTED},
        '{FUNC_REPORT, 1'b0, '0, '0, '0, CHK_NONE, FB_BUSY},
        '{FUNC_REPORT, 1'b1, '0, '0, '0, CHK_PRED, FB_BUSY}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [TMO_W-1:0]          i_cfg_wr_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_feedback;
    logic signed [COORD_W-1:0] i_coord_0, i_coord_1, i_coord_2, i_coord_3, i_coord_4, i_coord_5;
    logic signed [COORD_W-1:0] i_cart_x, i_cart_y, i_cart_z;

    t_item      in_item;
    t_check     in_check;
    logic [1:0] in_fb;

    int send_idle;
    int recv_idle;
    int cur_timeout;
    int handled_items;
    int mismatches;

    logic [1:0] feedback_q [$];

    t_phase                             pr_phase;
    logic [WAIT_W-1:0]                  pr_wait;
    t_kind                              pr_kind;
    logic [MAX_LANES-1:0][COORD_W-1:0]  pr_target;
    logic [TOL_W-1:0]                   pr_tol;
    logic [TMO_W-1:0]                   pr_timeout;
    bit                                 pr_has;
    logic [1:0]                         pr_fb;
    bit                                 pr_live;

    assign i_coord_0 = in_item.coord[0];
    assign i_coord_1 = in_item.coord[1];
    assign i_coord_2 = in_item.coord[2];
    assign i_coord_3 = in_item.coord[3];
    assign i_coord_4 = in_item.coord[4];
    assign i_coord_5 = in_item.coord[5];
    assign i_cart_x = in_item.cart[0];
    assign i_cart_y = in_item.cart[1];
    assign i_cart_z = in_item.cart[2];

    motion_completion_verifier_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (in_item.func),
        .i_motion_done (in_item.done),
        .i_tolerance   (in_item.tol),
        .i_coord_0     (i_coord_0),
        .i_coord_1     (i_coord_1),
        .i_coord_2     (i_coord_2),
        .i_coord_3     (i_coord_3),
        .i_coord_4     (i_coord_4),
        .i_coord_5     (i_coord_5),
        .i_cart_x      (i_cart_x),
        .i_cart_y      (i_cart_y),
        .i_cart_z      (i_cart_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_feedback    (o_feedback)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_motion_completion_verifier_top failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    function automatic logic [1:0] judge_position(input t_item it);
        longint d;
        longint sum;
        longint worst;
        logic   ok;
        ok = 1'b0;
        sum = 0;
        worst = 0;
        if (pr_kind == KIND_LIN || pr_kind == KIND_JCART) begin
            for (int i = 0; i < CART_LANES; i++) begin
                d = longint'($signed(it.cart[i])) - longint'($signed(pr_target[i]));
                sum += d * d;
            end
            ok = (sum <= longint'(pr_tol) * longint'(pr_tol));
        end else if (pr_kind == KIND_JOINT) begin
            for (int i = 0; i < JOINTS; i++) begin
                d = longint'($signed(it.coord[i])) - longint'($signed(pr_target[i]));
                if (d < 0) d = -d;
                if (d > worst) worst = d;
            end
            ok = (worst <= longint'(pr_tol));
        end
        return ok ? FB_REACHED : FB_FAILED;
    endfunction

    task predict_feedback(input t_item it);
        pr_has = 1'b0;
        pr_fb = FB_BUSY;
        pr_live = 1'b0;
        case (it.func)
            FUNC_TICK: begin
                if (pr_phase == PH_WAIT) begin
                    pr_live = 1'b1;
                    if (pr_wait != WAIT_MAX) pr_wait = pr_wait + 1'b1;
                end
            end
            FUNC_REPORT: begin
                if (pr_phase == PH_WAIT) begin
                    pr_live = 1'b1;
                    if (!it.done) begin
                        pr_phase = PH_MOVING;
                    end else if (pr_wait > pr_timeout) begin
                        pr_fb = judge_position(it);
                        pr_has = 1'b1;
                        pr_phase = PH_IDLE;
                    end
                end else if (pr_phase == PH_MOVING) begin
                    pr_live = 1'b1;
                    if (it.done) begin
                        pr_fb = judge_position(it);
                        pr_has = 1'b1;
                        pr_phase = PH_IDLE;
                    end
                end
            end
            FUNC_LIN, FUNC_JCART, FUNC_JOINT, FUNC_UNSUP: begin
                pr_live = 1'b1;
                pr_has = 1'b1;
                if (pr_phase != PH_IDLE) begin
                    pr_fb = FB_BUSY;
                end else begin
                    pr_kind = t_kind'(2'(it.func - FUNC_LIN));
                    pr_target = it.coord;
                    pr_tol = it.tol;
                    pr_phase = PH_WAIT;
                    pr_wait = '0;
                    pr_fb = FB_ACCEPTED;
                end
            end
            default: begin
            end
        endcase
    endtask

    task note_mismatch(input string what, input logic [1:0] want, input logic [1:0] got);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task enqueue_fb(input logic [1:0] fb);
        feedback_q = {feedback_q, fb};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pr_phase = PH_IDLE;
            pr_wait = '0;
            pr_kind = KIND_LIN;
            pr_target = '0;
            pr_tol = '0;
            pr_timeout = TIMEOUT_RST;
        end else begin
            if (i_cfg_wr_en) pr_timeout = i_cfg_wr_data;
            if (i_in_valid && !o_in_stall) begin
                predict_feedback(in_item);
                if (pr_live) handled_items++;
                if (in_check == CHK_FB) enqueue_fb(in_fb);
                else if (in_check == CHK_PRED && pr_has) enqueue_fb(pr_fb);
            end
            if (o_out_valid && !i_out_stall) begin
                if (feedback_q.size() == 0) note_mismatch("unexpected feedback", 2'bxx, o_feedback);
                else if (o_feedback !== feedback_q[0]) begin
                    note_mismatch("feedback", feedback_q[0], o_feedback);
                    void'(feedback_q.pop_front());
                end else begin
                    void'(feedback_q.pop_front());
                end
            end
        end
    end

    task automatic drive_item(input t_item it, input t_check chk, input logic [1:0] fb);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_item <= it;
        in_check <= chk;
        in_fb <= fb;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        int w;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (w = 0; w < DRAIN_LIMIT && feedback_q.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input int ticks);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= TMO_W'(ticks);
        cur_timeout = ticks;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_item noise_item();
        t_item it;
        it.func = 3'($urandom_range(0, 7));
        it.done = 1'($urandom);
        it.tol = TOL_W'($urandom);
        for (int i = 0; i < MAX_LANES; i++) it.coord[i] = COORD_W'($urandom);
        for (int i = 0; i < CART_LANES; i++) it.cart[i] = COORD_W'($urandom);
        return it;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c, input int span);
        return COORD_W'(int'($signed(c)) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic run_motion();
        t_item                             it;
        logic [MAX_LANES-1:0][COORD_W-1:0] goal;
        logic [TOL_W-1:0]                  tol;
        int                                span;
        int                                n;
        tol = ($urandom_range(0, 7) == 0) ? TOL_W'($urandom) : TOL_W'($urandom_range(0, 3000));
        for (int i = 0; i < MAX_LANES; i++) goal[i] = rand_coord();
        it = noise_item();
        it.func = FUNC_LIN + 3'($urandom_range(0, 3));
        it.tol = tol;
        it.coord = goal;
        drive_item(it, CHK_PRED, FB_BUSY);
        n = $urandom_range(0, cur_timeout + 2);
        for (int k = 0; k < n; k++) begin
            it = noise_item();
            if ($urandom_range(0, 11) == 0) it.func = FUNC_LIN + 3'($urandom_range(0, 3));
            else it.func = FUNC_TICK;
            drive_item(it, CHK_PRED, FB_BUSY);
        end
        if ($urandom_range(0, 3) != 0) begin
            it = noise_item();
            it.func = FUNC_REPORT;
            it.done = 1'b0;
            drive_item(it, CHK_PRED, FB_BUSY);
            n = $urandom_range(0, 2);
            for (int k = 0; k < n; k++) begin
                it = noise_item();
                it.func = FUNC_TICK;
                drive_item(it, CHK_PRED, FB_BUSY);
            end
        end
        span = int'(tol) + int'(tol) / 8 + 2;
        it = noise_item();
        it.func = FUNC_REPORT;
        it.done = 1'b1;
        for (int i = 0; i < MAX_LANES; i++) it.coord[i] = near(goal[i], span);
        for (int i = 0; i < CART_LANES; i++) it.cart[i] = near(goal[i], span);
        drive_item(it, CHK_PRED, FB_BUSY);
    endtask

    initial begin
        t_item it;
        int    goal;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        in_item = '0;
        in_check = CHK_NONE;
        in_fb = FB_BUSY;
        send_idle = 0;
        recv_idle = 0;
        cur_timeout = 2000;
        handled_items = 0;
        mismatches = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            it.func = DIR_ROWS[r].func;
            it.done = DIR_ROWS[r].done;
            it.tol = DIR_ROWS[r].tol;
            it.coord = {MAX_LANES{DIR_ROWS[r].coord}};
            it.cart = {CART_LANES{DIR_ROWS[r].cart}};
            drive_item(it, DIR_ROWS[r].check, DIR_ROWS[r].fb);
        end

        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 9 : (p == 1) ? 53 : 0;
            recv_idle = (p == 0) ? 53 : (p == 1) ? 9 : 0;
            write_timeout((p == 0) ? 0 : (p == 1) ? $urandom_range(1, 12) : 3);
            goal = handled_items + ITEMS_PER_PHASE;
            while (handled_items < goal) begin
                if ($urandom_range(0, 99) < 15) drive_item(noise_item(), CHK_PRED, FB_BUSY);
                else run_motion();
            end
        end

        settle();
        while (feedback_q.size() != 0) note_mismatch("missing feedback", feedback_q.pop_front(), 2'bxx);
        if (mismatches == 0) $display("tb_motion_completion_verifier_top passed");
        else $display("tb_motion_completion_verifier_top failed");
        $finish;
    end

endmodule
